// File: rtl/wbss_pkg.sv
// ----------------------------------------------------------------------------
// wbss_pkg
// Shared types, constants and helpers for the wildcard byte signature
// scanner: configuration bundle, register indexes and length handling.
// ----------------------------------------------------------------------------
package wbss_pkg;

    // Window depth and offset counter width
    localparam int MAX_PATTERN  = 16;
    localparam int OFFSET_WIDTH = 32;
    localparam int LEN_W        = $clog2(MAX_PATTERN);

    // Signature bytes held in the two pattern registers
    localparam int SIG_BYTES    = 16;

    // Configuration port geometry
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WILD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OCC    = 3'd4;

    localparam logic [15:0] MATCH_CNT_MAX = 16'hFFFF;
    localparam logic [OFFSET_WIDTH-1:0] POS_MAX = '1;

    typedef logic [7:0] byte_t;

    // Configuration register bundle
    typedef struct packed {
        logic [63:0] pat_lo;
        logic [63:0] pat_hi;
        logic [15:0] wild;
        logic [4:0]  plen;
        logic [15:0] occ;
    } cfg_t;

    // Effective pattern length minus one: zero acts as one, clipped at window
    function automatic logic [LEN_W-1:0] eff_len_m1(input logic [4:0] plen);
        logic [LEN_W-1:0] r;
        if (plen == 5'd0) begin
            r = '0;
        end else if (32'(plen) > MAX_PATTERN) begin
            r = LEN_W'(MAX_PATTERN - 1);
        end else begin
            r = LEN_W'(plen - 5'd1);
        end
        return r;
    endfunction

    // Signature byte k; bytes past the register pair are zero
    function automatic byte_t sig_byte(input cfg_t c, input int unsigned k);
        logic [127:0] sig;
        byte_t        r;
        sig = {c.pat_hi, c.pat_lo};
        if (k < SIG_BYTES) begin
            r = sig[8*k +: 8];
        end else begin
            r = '0;
        end
        return r;
    endfunction

    // Wildcard bit of signature byte k; never set past the register
    function automatic logic sig_wild(input cfg_t c, input int unsigned k);
        logic r;
        if (k < SIG_BYTES) begin
            r = c.wild[k];
        end else begin
            r = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: rtl/wbss_cfg_regs.sv
// ----------------------------------------------------------------------------
// wbss_cfg_regs
// Configuration register file, written one register per handshake.
// Writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module wbss_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [wbss_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [wbss_pkg::CFG_DATA_W-1:0] wr_data,
    output wbss_pkg::cfg_t                  cfg
);
    import wbss_pkg::*;

    cfg_t cfg_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pat_lo <= '0;
            cfg_reg.pat_hi <= '0;
            cfg_reg.wild   <= '0;
            cfg_reg.plen   <= 5'd1;
            cfg_reg.occ    <= '0;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_PAT_LO: cfg_reg.pat_lo <= wr_data;
                REG_PAT_HI: cfg_reg.pat_hi <= wr_data;
                REG_WILD:   cfg_reg.wild   <= wr_data[15:0];
                REG_PLEN:   cfg_reg.plen   <= wr_data[4:0];
                REG_OCC:    cfg_reg.occ    <= wr_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/wbss_matcher.sv
// ----------------------------------------------------------------------------
// wbss_matcher
// Byte window of the most recent bytes and the parallel wildcard compare
// of the newest window (including the incoming byte) against the signature.
// ----------------------------------------------------------------------------
module wbss_matcher (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step,     // item processed this cycle
    input  wbss_pkg::byte_t                in_byte,
    input  logic                           in_last,
    input  wbss_pkg::cfg_t                 cfg,
    input  logic [wbss_pkg::LEN_W-1:0]     len_m1,
    output logic                           hit
);
    import wbss_pkg::*;

    byte_t win_reg [MAX_PATTERN];
    byte_t win_cur [MAX_PATTERN];
    logic  [MAX_PATTERN-1:0] lane_ok;

    // Window as seen once the incoming byte is shifted in; entry 0 newest
    always_comb begin
        win_cur[0] = in_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            win_cur[j] = win_reg[j-1];
        end
    end

    // Window entry j lines up with signature byte len_m1 - j
    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            logic [LEN_W-1:0] k;
            k = len_m1 - LEN_W'(j);
            if (LEN_W'(j) > len_m1) begin
                lane_ok[j] = 1'b1;
            end else begin
                lane_ok[j] = sig_wild(cfg, 32'(k)) || (win_cur[j] == sig_byte(cfg, 32'(k)));
            end
        end
    end

    assign hit = &lane_ok;

    // Shift on every processed item, clear at region end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                win_reg[j] <= '0;
            end
        end else if (step) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                win_reg[j] <= in_last ? '0 : win_cur[j];
            end
        end
    end

endmodule

// File: rtl/wildcard_byte_signature_scanner_top.sv
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scanner_top
// Path: an accepted byte passes the input register, then the output register
//   that drives m_tvalid; a waiting result stalls the input.
// Throughput: one byte per cycle while a waiting result does not stall it;
//   input register, combinational window compare, counter update, output register.
// Reset: aresetn (synchronous, active low) clears window, counters and
//   configuration (pattern length 1, all else zero); no clearing pass.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scanner_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Byte stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic                            s_tlast,   // region_end
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [31:0] match_offset
    output logic                            m_tuser,   // [0] found
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wbss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wbss_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wbss_pkg::*;

    cfg_t             cfg;
    logic [LEN_W-1:0] len_m1;

    logic             in_valid_reg;
    byte_t            in_byte_reg;
    logic             in_last_reg;

    logic [OFFSET_WIDTH-1:0] pos_reg;
    logic [15:0]             matches_reg;
    logic                    given_reg;

    logic        out_valid_reg;
    logic        out_found_reg;
    logic [31:0] out_offset_reg;

    logic                    step;
    logic                    hit;
    logic                    pos_ok;
    logic                    test;
    logic                    sel;
    logic                    emit;
    logic [OFFSET_WIDTH-1:0] start;

    // Configuration
    assign cfg_ready = 1'b1;

    wbss_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign len_m1 = eff_len_m1(cfg.plen);

    // Item in the input register moves on when the output register frees up
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    wbss_matcher u_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .cfg     (cfg),
        .len_m1  (len_m1),
        .hit     (hit)
    );

    // Match selection
    assign pos_ok = pos_reg >= OFFSET_WIDTH'(len_m1);
    assign test   = !given_reg && pos_ok && hit;
    assign sel    = test && (matches_reg == cfg.occ);
    assign emit   = sel || (in_last_reg && !given_reg);
    assign start  = pos_reg - OFFSET_WIDTH'(len_m1);

    // Region counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            matches_reg <= '0;
            given_reg   <= 1'b0;
        end else if (step) begin
            if (in_last_reg) begin
                pos_reg     <= '0;
                matches_reg <= '0;
                given_reg   <= 1'b0;
            end else begin
                if (pos_reg != POS_MAX) begin
                    pos_reg <= pos_reg + OFFSET_WIDTH'(1);
                end
                if (sel) begin
                    given_reg <= 1'b1;
                end else if (test && (matches_reg != MATCH_CNT_MAX)) begin
                    matches_reg <= matches_reg + 16'd1;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            out_found_reg  <= sel;
            out_offset_reg <= sel ? start[31:0] : 32'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_offset_reg;
    assign m_tuser  = out_found_reg;

endmodule
